// ----- rtl/gb3_pkg.sv -----
// Shared types, register codes and helpers for the 3x3 Gaussian blur block.
package gb3_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Configuration register map
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1
  } cfg_reg_t;

  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  // Queue between the front and back parts
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  // One new window column plus the decisions the front made for it
  typedef struct packed {
    logic [7:0] up;     // two rows above
    logic [7:0] lo;     // one row above
    logic [7:0] cur;    // incoming pixel, zero for a flush
    logic       emit;   // this column completes an output pixel
    logic       top;    // output row has a row above
    logic       bot;    // output row has a row below
    logic       left;   // output column has a column to the left
    logic       right;  // output column has a column to the right
    logic       last;   // output is the last pixel of the frame
  } tap_col_t;

  // Clamp a frame size to 1..lim and return it minus one
  function automatic int unsigned size_m1(int unsigned v, int unsigned lim);
    if (v == 0) begin
      return 0;
    end
    if (v > lim) begin
      return lim - 1;
    end
    return v - 1;
  endfunction

endpackage

// ----- rtl/gb3_queue.sv -----
// Short word queue that decouples the front part from the back part.
module gb3_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gb3_pkg::tap_col_t   push_data,
  input  logic                pop,
  output logic                empty,
  output logic [gb3_pkg::QLW-1:0] level,
  output gb3_pkg::tap_col_t   head
);
  import gb3_pkg::*;

  tap_col_t          slots_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QLW-1:0]    level_r, level_nxt;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  assign empty = (level_r == '0);
  assign level = level_r;
  assign head  = slots_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r != QLW'(QDEPTH) || pop))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (level_r != '0))
    else $error("queue popped while empty");

endmodule

// ----- rtl/gb3_front.sv -----
// Front part: takes input words, tracks stream position, runs the line store.
module gb3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  gb3_pkg::op_t                  in_op,
  input  logic [7:0]                    in_pixel_in,
  output logic                          in_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [gb3_pkg::QLW-1:0]       q_level,
  output logic                          q_push,
  output gb3_pkg::tap_col_t             q_data,
  output logic                          win_clear
);
  import gb3_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned W_M1_RST = size_m1(RESET_WIDTH, MAX_WIDTH);
  localparam int unsigned H_M1_RST = size_m1(RESET_HEIGHT, MAX_HEIGHT);

  // Word held between the store read and the store write
  typedef struct packed {
    logic [XW-1:0] addr;
    logic [7:0]    cur;
    logic          emit;
    logic          top;
    logic          bot;
    logic          left;
    logic          right;
    logic          last;
  } s1_t;

  logic [XW-1:0] width_m1_r;
  logic [YW-1:0] height_m1_r;
  logic [XW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [XW-1:0] out_col_r, out_col_nxt;
  logic [YW-1:0] out_row_r, out_row_nxt;
  logic          s1_valid_r;
  s1_t           s1_r, s1_nxt;

  logic [15:0]   lines_mem [MAX_WIDTH];
  logic [15:0]   rd_q_r;
  logic          fwd_r;
  logic [15:0]   fwd_data_r;
  logic [15:0]   rd_data;
  logic [15:0]   wr_data;

  logic accept, draining, is_flush, take, emit, last, cfg_hit;
  logic in_col_end, out_col_end, out_row_end;

  // Classify the word
  assign accept      = in_push && !in_full;
  assign draining    = in_row_r > RW'(height_m1_r);
  assign is_flush    = (in_op == OP_FLUSH);
  assign take        = accept && (is_flush == draining);
  assign emit        = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign in_col_end  = (in_col_r == width_m1_r);
  assign out_col_end = (out_col_r == width_m1_r);
  assign out_row_end = (out_row_r == height_m1_r);
  assign last        = emit && out_col_end && out_row_end;
  assign cfg_ready   = 1'b1;
  assign cfg_hit     = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
                                     (cfg_index == REG_FRAME_HEIGHT));
  assign win_clear   = cfg_hit;

  // Hold back input while the queue may not take every word in flight
  assign in_full = (q_level + QLW'(s1_valid_r)) >= QLW'(QDEPTH);

  // Advance input and output positions
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit || (take && last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (in_col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  // Build the word for the store stage
  always_comb begin
    s1_nxt.addr  = in_col_r;
    s1_nxt.cur   = is_flush ? 8'd0 : in_pixel_in;
    s1_nxt.emit  = emit;
    s1_nxt.top   = (out_row_r != '0);
    s1_nxt.bot   = !out_row_end;
    s1_nxt.left  = (out_col_r != '0);
    s1_nxt.right = !out_col_end;
    s1_nxt.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_m1_r  <= XW'(W_M1_RST);
      height_m1_r <= YW'(H_M1_RST);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_FRAME_WIDTH)) begin
        width_m1_r <= XW'(size_m1(32'(cfg_wdata[WIDTH_REG_W-1:0]), MAX_WIDTH));
      end
      if (cfg_valid && (cfg_index == REG_FRAME_HEIGHT)) begin
        height_m1_r <= YW'(size_m1(32'(cfg_wdata[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
      end
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      s1_valid_r <= take;
    end
  end

  // Capture the store-stage word
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  // Line store: {two rows above, one row above} per column
  always_ff @(posedge clk) begin
    if (take) begin
      rd_q_r <= lines_mem[in_col_r];
    end
    if (s1_valid_r) begin
      lines_mem[s1_r.addr] <= wr_data;
    end
  end

  // Forward a write that lands in the same cycle as a read of its column
  always_ff @(posedge clk) begin
    fwd_r      <= s1_valid_r && (s1_r.addr == in_col_r);
    fwd_data_r <= wr_data;
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;
  assign wr_data = {rd_data[7:0], s1_r.cur};

  // Hand the column to the queue
  assign q_push = s1_valid_r;
  always_comb begin
    q_data.up    = rd_data[15:8];
    q_data.lo    = rd_data[7:0];
    q_data.cur   = s1_r.cur;
    q_data.emit  = s1_r.emit;
    q_data.top   = s1_r.top;
    q_data.bot   = s1_r.bot;
    q_data.left  = s1_r.left;
    q_data.right = s1_r.right;
    q_data.last  = s1_r.last;
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col_r <= width_m1_r) && (out_col_r <= width_m1_r))
    else $error("column position beyond frame width");

  a_out_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r <= height_m1_r)
    else $error("output row beyond frame height");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |=> (in_col_r == '0) && (in_row_r == '0) && (out_row_r == '0))
    else $error("frame did not restart after its last pixel");

endmodule

// ----- rtl/gb3_back.sv -----
// Back part: 3x3 window, weighted sum and the output register.
module gb3_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  gb3_pkg::tap_col_t q_data,
  output logic              q_pop,
  input  logic              win_clear,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_pixel_out,
  output logic              out_frame_last
);
  import gb3_pkg::*;

  // Two stored columns; the third is the incoming queue word. Index 0 is top.
  logic [2:0][7:0] col_a_r;   // older
  logic [2:0][7:0] col_b_r;   // center
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      pix_r;
  logic            last_r;
  logic            adv;
  logic [11:0]     sum;

  // Take the next column when its result has somewhere to go
  assign adv   = !q_empty && (!q_data.emit || !out_valid_r || out_pop);
  assign q_pop = adv;

  // Weighted sum over the window after the shift
  always_comb begin
    sum = 12'({col_b_r[1], 2'b00});
    if (q_data.top) begin
      sum = sum + 12'({col_b_r[0], 1'b0});
    end
    if (q_data.bot) begin
      sum = sum + 12'({col_b_r[2], 1'b0});
    end
    if (q_data.left) begin
      sum = sum + 12'({col_a_r[1], 1'b0});
      if (q_data.top) begin
        sum = sum + 12'(col_a_r[0]);
      end
      if (q_data.bot) begin
        sum = sum + 12'(col_a_r[2]);
      end
    end
    if (q_data.right) begin
      sum = sum + 12'({q_data.lo, 1'b0});
      if (q_data.top) begin
        sum = sum + 12'(q_data.up);
      end
      if (q_data.bot) begin
        sum = sum + 12'(q_data.cur);
      end
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && q_data.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Shift the window, drop it at frame restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_a_r     <= '0;
      col_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (win_clear || (adv && q_data.last)) begin
        col_a_r <= '0;
        col_b_r <= '0;
      end else if (adv) begin
        col_a_r <= col_b_r;
        col_b_r <= {q_data.cur, q_data.lo, q_data.up};
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (adv && q_data.emit) begin
      pix_r  <= sum[11:4];
      last_r <= q_data.last;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_pixel_out  = pix_r;
  assign out_frame_last = last_r;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> $stable(pix_r) && $stable(last_r))
    else $error("waiting result word overwritten");

endmodule

// ----- rtl/gaussian_blur_3x3.sv -----
// Top level of the 3x3 Gaussian blur: front part, word queue, back part.
//
// Streams 8-bit grey pixels of one frame in raster order and returns each
// pixel's 1-2-1 / 2-4-2 / 1-2-1 weighted sum shifted right by four; taps
// outside the frame count as zero, so borders darken. Results lag the input
// by one row plus one pixel: after the frame's last pixel, push one flush
// word per pending result (frame width plus one) to drain them; the last
// result carries frame_last, and the next pixel word starts a new frame.
// Pixel words after the frame's end and flush words before it are taken and
// dropped. Writing frame_width or frame_height (index 0 and 1, clamped to
// 1..MAX_WIDTH and 1..MAX_HEIGHT) restarts the frame; write only while the
// block is idle. Sustained rate is one word per clock while in_full stays
// low; a result passes three register stages (position logic and line-store
// read, line-store write, sum and output register) after the word that
// completes it is taken. The four-word queue between the line store and the
// window absorbs output stalls; the line store needs no clearing pass after
// reset.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  gb3_pkg::op_t                   in_op,
  input  logic [7:0]                     in_pixel_in,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_pixel_out,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gb3_pkg::*;

  logic           q_push;
  tap_col_t       q_push_data;
  logic           q_pop;
  logic           q_empty;
  logic [QLW-1:0] q_level;
  tap_col_t       q_head;
  logic           win_clear;

  gb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_op       (in_op),
    .in_pixel_in (in_pixel_in),
    .in_full     (in_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_level     (q_level),
    .q_push      (q_push),
    .q_data      (q_push_data),
    .win_clear   (win_clear)
  );

  gb3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .empty     (q_empty),
    .level     (q_level),
    .head      (q_head)
  );

  gb3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_head),
    .q_pop          (q_pop),
    .win_clear      (win_clear),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

endmodule
